### rtl/rfbw_pkg.sv
// Shared types, widths and codes for the rotated frame-buffer window writer.
package rfbw_pkg;

  localparam int MAX_SIDE   = 1024;
  localparam int SIDE_W     = $clog2(MAX_SIDE);
  localparam int POS_W      = SIDE_W + 1;
  localparam int DATA_W     = 16;
  localparam int ADDR_W     = 2 * SIDE_W;
  localparam int CFG_IDX_W  = 2;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [SIDE_W-1:0] PANEL_WIDTH_RST  = SIDE_W'(320);
  localparam logic [SIDE_W-1:0] PANEL_HEIGHT_RST = SIDE_W'(480);

  // request kinds
  localparam logic [1:0] REQ_SET_WIN = 2'd0;
  localparam logic [1:0] REQ_STREAM  = 2'd1;
  localparam logic [1:0] REQ_POINT   = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PANEL_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_PANEL_HEIGHT = CFG_IDX_W'(1);

  // one on-panel pixel handed from the front to the back
  typedef struct packed {
    logic [SIDE_W-1:0] col;
    logic [SIDE_W-1:0] row;
    logic [DATA_W-1:0] color;
  } pix_t;

  function automatic logic [DATA_W-1:0] swap_bytes(input logic [DATA_W-1:0] c);
    swap_bytes = {c[7:0], c[15:8]};
  endfunction

endpackage

### rtl/rfbw_front.sv
// Front end: takes requests, keeps window and cursor, passes on-panel pixels.
module rfbw_front import rfbw_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        req_type,
  input  logic              burst_start,
  input  logic [POS_W-1:0]  pos_x,
  input  logic [POS_W-1:0]  pos_y,
  input  logic [SIDE_W-1:0] span_w,
  input  logic [SIDE_W-1:0] span_h,
  input  logic [DATA_W-1:0] pixel_color,
  input  logic [SIDE_W-1:0] panel_width,
  input  logic [SIDE_W-1:0] panel_height,
  output logic              push,
  output pix_t              push_item,
  input  logic              q_ready
);

  logic [SIDE_W-1:0] win_left, win_top, win_cols, win_rows;
  logic [SIDE_W-1:0] cursor_col, cursor_row;
  logic [SIDE_W-1:0] win_left_next, win_top_next, win_cols_next, win_rows_next;
  logic [SIDE_W-1:0] cursor_col_next, cursor_row_next;

  logic              acc;
  logic              emit;
  logic [SIDE_W-1:0] cur_col, cur_row;
  logic [SIDE_W:0]   col_inc, row_inc, col_end, row_end, x_end, y_end;
  logic              wrap_col, wrap_row, set_bad, win_empty;

  assign in_ready = q_ready;
  assign acc      = in_valid && q_ready;

  always_comb begin
    cur_col   = burst_start ? win_left : cursor_col;
    cur_row   = burst_start ? win_top  : cursor_row;
    col_inc   = {1'b0, cur_col} + (SIDE_W+1)'(1);
    row_inc   = {1'b0, cur_row} + (SIDE_W+1)'(1);
    col_end   = {1'b0, win_left} + {1'b0, win_cols};
    row_end   = {1'b0, win_top} + {1'b0, win_rows};
    wrap_col  = col_inc >= col_end;
    wrap_row  = row_inc >= row_end;
    x_end     = {1'b0, pos_x[SIDE_W-1:0]} + {1'b0, span_w};
    y_end     = {1'b0, pos_y[SIDE_W-1:0]} + {1'b0, span_h};
    set_bad   = pos_x[POS_W-1] || pos_y[POS_W-1] ||
                (x_end > {1'b0, panel_width}) || (y_end > {1'b0, panel_height});
    win_empty = (win_cols == '0) || (win_rows == '0);

    win_left_next   = win_left;
    win_top_next    = win_top;
    win_cols_next   = win_cols;
    win_rows_next   = win_rows;
    cursor_col_next = cursor_col;
    cursor_row_next = cursor_row;
    emit            = 1'b0;
    push_item.col   = cur_col;
    push_item.row   = cur_row;
    push_item.color = pixel_color;

    case (req_type)
      REQ_SET_WIN: begin
        if (set_bad) begin
          win_left_next = '0;
          win_top_next  = '0;
          win_cols_next = '0;
          win_rows_next = '0;
        end else begin
          win_left_next = pos_x[SIDE_W-1:0];
          win_top_next  = pos_y[SIDE_W-1:0];
          win_cols_next = span_w;
          win_rows_next = span_h;
        end
        cursor_col_next = win_left_next;
        cursor_row_next = win_top_next;
      end
      REQ_STREAM: begin
        if (!win_empty) begin
          // a stale cursor off the panel writes nothing but still steps
          emit = (cur_col < panel_width) && (cur_row < panel_height);
          if (wrap_col) begin
            cursor_col_next = win_left;
            cursor_row_next = wrap_row ? win_top : row_inc[SIDE_W-1:0];
          end else begin
            cursor_col_next = col_inc[SIDE_W-1:0];
            cursor_row_next = cur_row;
          end
        end
      end
      REQ_POINT: begin
        push_item.col = pos_x[SIDE_W-1:0];
        push_item.row = pos_y[SIDE_W-1:0];
        emit = !pos_x[POS_W-1] && !pos_y[POS_W-1] &&
               (pos_x[SIDE_W-1:0] < panel_width) && (pos_y[SIDE_W-1:0] < panel_height);
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  assign push = acc && emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      win_left   <= '0;
      win_top    <= '0;
      win_cols   <= '0;
      win_rows   <= '0;
      cursor_col <= '0;
      cursor_row <= '0;
    end else if (acc) begin
      win_left   <= win_left_next;
      win_top    <= win_top_next;
      win_cols   <= win_cols_next;
      win_rows   <= win_rows_next;
      cursor_col <= cursor_col_next;
      cursor_row <= cursor_row_next;
    end
  end

  a_set_win_homes_cursor: assert property (@(posedge clk) disable iff (rst)
    (acc && req_type == REQ_SET_WIN) |=> (cursor_col == win_left && cursor_row == win_top))
    else $error("cursor not at window origin after set window");

endmodule

### rtl/rfbw_fifo.sv
// Short pixel queue between the front end and the address back end.
module rfbw_fifo import rfbw_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  pix_t push_item,
  output logic not_full,
  input  logic pop,
  output logic rd_valid,
  output pix_t rd_item
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  pix_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign not_full = count != CNT_W'(DEPTH);
  assign rd_valid = count != '0;
  assign rd_item  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    push |-> (count < CNT_W'(DEPTH) || pop))
    else $error("push into full queue");

  a_no_underrun: assert property (@(posedge clk) disable iff (rst)
    (pop && !push) |=> (count == $past(count) - CNT_W'(1)))
    else $error("queue count lost on pop");

endmodule

### rtl/rfbw_back.sv
// Back end: rotated address multiply, byte swap and output register.
module rfbw_back import rfbw_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  pix_t              q_item,
  output logic              q_pop,
  input  logic [SIDE_W-1:0] panel_width,
  input  logic [SIDE_W-1:0] panel_height,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [ADDR_W-1:0] mem_addr,
  output logic [DATA_W-1:0] mem_data
);

  logic              s1_valid;
  logic [ADDR_W-1:0] s1_prod;
  logic [SIDE_W-1:0] s1_row;
  logic [DATA_W-1:0] s1_data;
  logic              out_en, s1_en;
  logic [SIDE_W-1:0] rev_col;

  assign out_en  = !out_valid || out_ready;
  assign s1_en   = !s1_valid || out_en;
  assign q_pop   = q_valid && s1_en;
  // column counted from the right edge, as the panel is stored rotated
  assign rev_col = panel_width - SIDE_W'(1) - q_item.col;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_en) begin
        s1_valid <= q_valid;
      end
      if (out_en) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_prod <= ADDR_W'(rev_col) * ADDR_W'(panel_height);
      s1_row  <= q_item.row;
      s1_data <= swap_bytes(q_item.color);
    end
    if (out_en && s1_valid) begin
      mem_addr <= s1_prod + ADDR_W'(s1_row);
      mem_data <= s1_data;
    end
  end

endmodule

### rtl/rotated_framebuffer_window_writer_top.sv
// Rotated frame-buffer window writer: a pixel request stream in, memory writes out.
// Takes one request per clock while the queue has room and gives at most one memory
// write word per request, registered in the queue, the multiply register and the
// output register, which holds it until taken. The rate holds while the output
// does not stall, through a single 10x10 address multiply stage; the queue absorbs
// short output stalls. Set-window requests and clipped pixels give no write. The
// user must write the panel size registers on the cfg channel only while the block
// is idle; the block does not enforce it, and the cfg channel is always ready.
module rotated_framebuffer_window_writer_top import rfbw_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [63:0]          s_tdata,  // pos_x, pos_y, span_w, span_h, pixel_color
  input  logic [2:0]           s_tuser,  // req_type, burst_start
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [39:0]          m_tdata,  // mem_addr, mem_data
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SIDE_W-1:0]    cfg_data
);

  logic [SIDE_W-1:0] panel_width, panel_height;
  logic              push, q_ready, q_valid, q_pop;
  pix_t              push_item, q_item;
  logic [ADDR_W-1:0] mem_addr;
  logic [DATA_W-1:0] mem_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      panel_width  <= PANEL_WIDTH_RST;
      panel_height <= PANEL_HEIGHT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_PANEL_WIDTH:  panel_width  <= cfg_data;
        CFG_PANEL_HEIGHT: panel_height <= cfg_data;
        default:          ;
      endcase
    end
  end

  rfbw_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .req_type     (s_tuser[1:0]),
    .burst_start  (s_tuser[2]),
    .pos_x        (s_tdata[10:0]),
    .pos_y        (s_tdata[21:11]),
    .span_w       (s_tdata[31:22]),
    .span_h       (s_tdata[41:32]),
    .pixel_color  (s_tdata[57:42]),
    .panel_width  (panel_width),
    .panel_height (panel_height),
    .push         (push),
    .push_item    (push_item),
    .q_ready      (q_ready)
  );

  rfbw_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .not_full  (q_ready),
    .pop       (q_pop),
    .rd_valid  (q_valid),
    .rd_item   (q_item)
  );

  rfbw_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop),
    .panel_width  (panel_width),
    .panel_height (panel_height),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .mem_addr     (mem_addr),
    .mem_data     (mem_data)
  );

  assign m_tdata = {4'b0, mem_data, mem_addr};

endmodule

### tb/tb_rotated_framebuffer_window_writer_top.sv
`timescale 1ns / 100ps
// Testbench for the rotated frame-buffer window writer: directed and random requests checked against a predictor.
module tb_rotated_framebuffer_window_writer_top;
  import rfbw_pkg::*;

  localparam int LIMIT_CYCLES = 200000;
  localparam int DRAIN_CYCLES = 12;
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = CFG_IDX_W'(2);

  typedef struct {
    logic [1:0]        kind;
    logic              burst;
    logic [POS_W-1:0]  x;
    logic [POS_W-1:0]  y;
    logic [SIDE_W-1:0] w;
    logic [SIDE_W-1:0] h;
    logic [DATA_W-1:0] color;
  } pix_req_t;

  typedef struct {
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
  } mem_write_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [63:0]          s_tdata = '0;  // pos_x, pos_y, span_w, span_h, pixel_color
  logic [2:0]           s_tuser = '0;  // req_type, burst_start
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [39:0]          m_tdata;       // mem_addr, mem_data
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [SIDE_W-1:0]    cfg_data = '0;

  rotated_framebuffer_window_writer_top DUT (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  always #1 clk = ~clk;

  // predictor state
  int pan_w = 320;
  int pan_h = 480;
  int win_left, win_top, win_cols, win_rows, cur_col, cur_row;

  pix_req_t   pending_reqs[$];
  mem_write_t expected_writes[$];
  mem_write_t want_wr;
  int  errors;
  int  cycles;
  bit  steady;  // no idling on either side
  int  burst_left, gap_left;
  int  stall_period = 1, stall_len, stall_phase;

  task automatic report_mismatch(input string what);
    $display("ERROR @%0t: %s", $realtime, what);
    errors++;
  endtask

  task automatic push_write(input int col, input int row, input logic [DATA_W-1:0] c);
    mem_write_t wr;
    int a;
    a = (pan_w - 1 - col) * pan_h + row;
    wr.addr = a[ADDR_W-1:0];
    wr.data = {c[7:0], c[15:8]};
    expected_writes.push_back(wr);
  endtask

  task automatic predict_mem_write(input pix_req_t r);
    int px;
    int py;
    px = int'($signed(r.x));
    py = int'($signed(r.y));
    case (r.kind)
      REQ_SET_WIN: begin
        if (px < 0 || py < 0 || px + int'(r.w) > pan_w || py + int'(r.h) > pan_h) begin
          win_left = 0; win_top = 0; win_cols = 0; win_rows = 0;
        end else begin
          win_left = px; win_top = py; win_cols = int'(r.w); win_rows = int'(r.h);
        end
        cur_col = win_left;
        cur_row = win_top;
      end
      REQ_STREAM: begin
        if (win_cols != 0 && win_rows != 0) begin
          if (r.burst) begin
            cur_col = win_left;
            cur_row = win_top;
          end
          // a cursor left outside a shrunk panel writes nothing but still moves
          if (cur_col < pan_w && cur_row < pan_h) push_write(cur_col, cur_row, r.color);
          cur_col++;
          if (cur_col >= win_left + win_cols) begin
            cur_col = win_left;
            cur_row++;
            if (cur_row >= win_top + win_rows) cur_row = win_top;
          end
          cur_col &= 'h3FF;
          cur_row &= 'h3FF;
        end
      end
      REQ_POINT: begin
        if (px >= 0 && py >= 0 && px < pan_w && py < pan_h) push_write(px, py, r.color);
      end
      default: ;
    endcase
  endtask

  // sender: bursts of random length with random gaps
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (s_tvalid && s_tready) predict_mem_write(pending_reqs.pop_front());
      if (!s_tvalid || s_tready) begin
        if (gap_left > 0 && !steady) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          s_tvalid <= 1'b1;
          s_tdata  <= {6'b0, pending_reqs[0].color, pending_reqs[0].h, pending_reqs[0].w,
                       pending_reqs[0].y, pending_reqs[0].x};
          s_tuser  <= {pending_reqs[0].burst, pending_reqs[0].kind};
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: periodic stall pattern, re-picked now and then; checks each word
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_writes.size() == 0) begin
          report_mismatch($sformatf("unexpected write word %h", m_tdata));
        end else begin
          want_wr = expected_writes.pop_front();
          if (m_tdata[19:0] !== want_wr.addr)
            report_mismatch($sformatf("mem_addr got %h want %h", m_tdata[19:0], want_wr.addr));
          if (m_tdata[35:20] !== want_wr.data)
            report_mismatch($sformatf("mem_data got %h want %h", m_tdata[35:20], want_wr.data));
        end
      end
      stall_phase++;
      if (stall_phase >= stall_period) begin
        stall_phase = 0;
        if ($urandom_range(0, 7) == 0) begin
          stall_period = $urandom_range(1, 8);
          stall_len = $urandom_range(0, stall_period - 1);
        end
      end
      m_tready <= steady || stall_phase >= stall_len;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input int val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[SIDE_W-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_PANEL_WIDTH) pan_w = val;
    else if (idx == CFG_PANEL_HEIGHT) pan_h = val;
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (pending_reqs.size() > 0 || expected_writes.size() > 0 || s_tvalid) @(negedge clk);
    // set-window words give no result; let the pipe empty
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic pix_req_t mk(input logic [1:0] kind, input bit burst, input int x,
                                  input int y, input int w, input int h, input int color);
    pix_req_t r;
    r.kind = kind; r.burst = burst;
    r.x = x[POS_W-1:0]; r.y = y[POS_W-1:0];
    r.w = w[SIDE_W-1:0]; r.h = h[SIDE_W-1:0];
    r.color = color[DATA_W-1:0];
    return r;
  endfunction

  function automatic pix_req_t rand_req();
    pix_req_t r;
    r.kind = 2'($urandom_range(0, 3));
    r.burst = 1'($urandom_range(0, 1));
    r.x = POS_W'($urandom_range(0, 2047));
    r.y = POS_W'($urandom_range(0, 2047));
    r.w = SIDE_W'($urandom_range(0, 1023));
    r.h = SIDE_W'($urandom_range(0, 1023));
    r.color = DATA_W'($urandom_range(0, 65535));
    return r;
  endfunction

  // one axis of a window that fits, mostly small
  task automatic fit_span(input int side, output logic [POS_W-1:0] org,
                          output logic [SIDE_W-1:0] span);
    int o;
    int s;
    if (side == 0) begin
      o = 0; s = 0;
    end else begin
      o = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(0, side - 1);
      s = ($urandom_range(0, 7) == 0) ? side - o : $urandom_range(1, (side - o < 12) ? side - o : 12);
    end
    org = o[POS_W-1:0];
    span = s[SIDE_W-1:0];
  endtask

  task automatic queue_random(input int count);
    int made;
    int run;
    pix_req_t r;
    made = 0;
    while (made < count) begin
      r = rand_req();
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          r.kind = REQ_SET_WIN;
          if ($urandom_range(0, 4) != 0) begin
            fit_span(pan_w, r.x, r.w);
            fit_span(pan_h, r.y, r.h);
          end else if ($urandom_range(0, 1) == 0) begin
            // one column or row wider than a fitting window, which can reach past the right or bottom edge
            fit_span(pan_w, r.x, r.w);
            fit_span(pan_h, r.y, r.h);
            if ($urandom_range(0, 1) == 0) r.w = r.w + SIDE_W'(1);
            else r.h = r.h + SIDE_W'(1);
          end
          pending_reqs.push_back(r);
          made++;
          run = $urandom_range(1, 40);
          for (int i = 0; i < run; i++) begin
            r = rand_req();
            r.kind = REQ_STREAM;
            r.burst = (i == 0) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 11) == 0);
            pending_reqs.push_back(r);
            made++;
          end
        end
        6, 7, 8: begin
          r.kind = REQ_POINT;
          if ($urandom_range(0, 3) != 0 && pan_w > 0 && pan_h > 0) begin
            r.x = POS_W'(($urandom_range(0, 5) == 0) ? pan_w - 1
                                                    : $urandom_range(0, pan_w - 1));
            r.y = POS_W'(($urandom_range(0, 5) == 0) ? pan_h - 1
                                                    : $urandom_range(0, pan_h - 1));
          end else if ($urandom_range(0, 1) == 0) begin
            r.x = POS_W'(pan_w);
            r.y = POS_W'(pan_h);
          end
          pending_reqs.push_back(r);
          made++;
        end
        default: begin
          pending_reqs.push_back(r);
          if (r.kind != REQ_UNUSED) made++;
        end
      endcase
    end
  endtask

  int cfg_w[7] = '{320, 1, 1023, 17, 0, 64, 200};
  int cfg_h[7] = '{480, 1, 1023, 9, 300, 1023, 0};

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset-size panel 320 x 480
    pending_reqs.push_back(mk(REQ_POINT, 0, 0, 0, 0, 0, 'h1234));
    pending_reqs.push_back(mk(REQ_POINT, 1, 319, 479, 1023, 1023, 'hFFFF));
    pending_reqs.push_back(mk(REQ_POINT, 0, 320, 0, 0, 0, 'hAAAA));
    pending_reqs.push_back(mk(REQ_POINT, 0, 0, 480, 0, 0, 'h5555));
    pending_reqs.push_back(mk(REQ_POINT, 0, -1, 5, 0, 0, 'h0F0F));
    pending_reqs.push_back(mk(REQ_POINT, 0, -1024, -1024, 0, 0, 'hF0F0));
    pending_reqs.push_back(mk(REQ_POINT, 0, 1023, 1023, 0, 0, 'h0001));
    pending_reqs.push_back(mk(REQ_STREAM, 1, 0, 0, 0, 0, 'h0000));  // empty window
    pending_reqs.push_back(mk(REQ_UNUSED, 1, 10, 10, 5, 5, 'hBEEF));
    pending_reqs.push_back(mk(REQ_SET_WIN, 0, -1, 0, 4, 4, 0));
    pending_reqs.push_back(mk(REQ_SET_WIN, 0, 300, 0, 21, 10, 0));
    pending_reqs.push_back(mk(REQ_SET_WIN, 0, 317, 477, 3, 3, 0));
    for (int i = 0; i < 10; i++)
      pending_reqs.push_back(mk(REQ_STREAM, i == 0, 0, 0, 0, 0, 'h0100 * i + i));
    pending_reqs.push_back(mk(REQ_STREAM, 1, 0, 0, 0, 0, 'h8001));
    pending_reqs.push_back(mk(REQ_SET_WIN, 0, 0, 0, 320, 480, 0));
    pending_reqs.push_back(mk(REQ_STREAM, 0, 0, 0, 0, 0, 'h00FF));
    pending_reqs.push_back(mk(REQ_SET_WIN, 0, 5, 5, 0, 3, 0));
    pending_reqs.push_back(mk(REQ_STREAM, 1, 0, 0, 0, 0, 'hFF00));
    wait_idle();

    write_cfg(CFG_UNUSED, 5);
    for (int p = 0; p < 7; p++) begin
      write_cfg(CFG_PANEL_WIDTH, cfg_w[p]);
      write_cfg(CFG_PANEL_HEIGHT, cfg_h[p]);
      @(negedge clk);
      steady = (p == 1);
      queue_random(150);
      wait_idle();
      if (p == 2) begin
        // shrink the panel under a live window: part of the stream falls off
        pending_reqs.push_back(mk(REQ_SET_WIN, 0, 990, 1000, 30, 20, 0));
        wait_idle();
        write_cfg(CFG_PANEL_WIDTH, 1000);
        write_cfg(CFG_PANEL_HEIGHT, 1010);
        @(negedge clk);
        for (int i = 0; i < 45; i++)
          pending_reqs.push_back(mk(REQ_STREAM, i == 0, 0, 0, 0, 0, 'h1111 * (i % 16)));
        wait_idle();
      end
    end

    if (expected_writes.size() != 0)
      report_mismatch($sformatf("%0d write words never arrived", expected_writes.size()));
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

### files.f
rtl/rfbw_pkg.sv
rtl/rfbw_front.sv
rtl/rfbw_fifo.sv
rtl/rfbw_back.sv
rtl/rotated_framebuffer_window_writer_top.sv
tb/tb_rotated_framebuffer_window_writer_top.sv
